[rtl/bvf_pkg.sv]
// ----------------------------------------------------------------------------
// bvf_pkg - shared types, constants and helpers for the bit vector finder
// Word geometry, action codes, memory request and result types, and the
// lowest-set-bit and lowest-set-flag priority encoders used by the find actions.
// ----------------------------------------------------------------------------
`default_nettype none

package bvf_pkg;

  // Word geometry of the store
  localparam int NUM_WORDS  = 32;
  localparam int WORD_BITS  = 32;
  localparam int WIDX_BITS  = $clog2(NUM_WORDS);
  localparam int SHIFT_BITS = $clog2(WORD_BITS);
  localparam int CNT_BITS   = 6;
  localparam int FOUND_BITS = 11;

  localparam logic [WORD_BITS-1:0] ALL_ONES   = 32'hFFFF_FFFF;
  localparam logic [WORD_BITS-1:0] ABOVE_MASK = 32'hFFFF_FFFE;

  // Action codes
  typedef enum logic [2:0] {
    ACT_TEST       = 3'd0,
    ACT_SET        = 3'd1,
    ACT_CLEAR      = 3'd2,
    ACT_FIND_FIRST = 3'd3,
    ACT_FIND_NEXT  = 3'd4,
    ACT_AND_WORD   = 3'd5,
    ACT_OR_WORD    = 3'd6,
    ACT_FILL       = 3'd7
  } action_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_FILL,
    ST_HOLD
  } state_t;

  // One access to the word store
  typedef struct packed {
    logic                 rd_en;
    logic [WIDX_BITS-1:0] rd_addr;
    logic                 wr_en;
    logic [WIDX_BITS-1:0] wr_addr;
    logic [WORD_BITS-1:0] wr_data;
  } mem_req_t;

  // One result beat
  typedef struct packed {
    logic                  out_of_range;
    logic [WORD_BITS-1:0]  combined_word;
    logic [FOUND_BITS-1:0] found_index;
    logic                  bit_value;
  } result_t;

  // Position of the lowest set bit (0 for an all-zero word)
  function automatic logic [SHIFT_BITS-1:0] lowest_set(input logic [WORD_BITS-1:0] w);
    logic [SHIFT_BITS-1:0] pos;
    pos = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (w[i]) begin
        pos = SHIFT_BITS'(i);
      end
    end
    return pos;
  endfunction

  // Lowest set flag among the words: valid bit and word number
  function automatic logic [WIDX_BITS:0] first_flag(input logic [NUM_WORDS-1:0] f);
    logic                 hit;
    logic [WIDX_BITS-1:0] idx;
    hit = 1'b0;
    idx = '0;
    for (int i = NUM_WORDS - 1; i >= 0; i--) begin
      if (f[i]) begin
        hit = 1'b1;
        idx = WIDX_BITS'(i);
      end
    end
    return {hit, idx};
  endfunction

endpackage

`default_nettype wire

[rtl/bit_vector_find_next.sv]
// ----------------------------------------------------------------------------
// bit_vector_find_next - bit vector with find-first and find-next set bit
// Top level: configuration register, beat packing and the store/sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats on in_* carry one action each: test, set or clear a bit,
//   find the first set bit, find the next set bit above bit_index, AND or
//   OR a word into the store, or fill all words in use. Every input beat
//   gives exactly one result beat on out_*.
//   cfg_wr_en/cfg_wr_data load words_in_use (0 acts as 1, above 32 as 32);
//   write it only while no action is in progress.
//   A fill writes one word per cycle through the single write port of the
//   word store, and a find next with nothing above its bit in its word
//   may fetch a second word. One action is worked on at a time; in_tready
//   returns when the result enters the output register.
//   Find actions use per-word nonzero flags to pick the word, then read it.
//   Reset clears the store to zeros (through per-word valid bits, no sweep)
//   and sets words_in_use to 32. When out_tready is low, the result waits
//   in the output register, a second one in a holding register, and no new
//   beat is taken until a result slot is free.
// ----------------------------------------------------------------------------
`default_nettype none

module bit_vector_find_next
  import bvf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // action, bit_index, word_index, operand_word, fill_value, zero pad
  input  wire logic [55:0] in_tdata,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // bit_value, found_index, combined_word, out_of_range, zero pad
  output logic [47:0]      out_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  input  wire logic        cfg_wr_en,
  input  wire logic [5:0]  cfg_wr_data
);

  logic [CNT_BITS-1:0]  words_in_use_r, words_in_use_nxt;
  logic [CNT_BITS-1:0]  count;
  mem_req_t             mem_req;
  logic [WORD_BITS-1:0] rd_data;
  logic [NUM_WORDS-1:0] nz_flags;
  result_t              out_res;

  // Configuration register
  assign words_in_use_nxt = cfg_wr_en ? cfg_wr_data : words_in_use_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      words_in_use_r <= CNT_BITS'(32);
    end else begin
      words_in_use_r <= words_in_use_nxt;
    end
  end

  // Clamp to 1..NUM_WORDS
  always_comb begin
    if (words_in_use_r == '0) begin
      count = CNT_BITS'(1);
    end else if (words_in_use_r > CNT_BITS'(NUM_WORDS)) begin
      count = CNT_BITS'(NUM_WORDS);
    end else begin
      count = words_in_use_r;
    end
  end

  bvf_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .action       (action_t'(in_tdata[2:0])),
    .bit_index    (in_tdata[12:3]),
    .word_index   (in_tdata[17:13]),
    .operand_word (in_tdata[49:18]),
    .fill_value   (in_tdata[50]),
    .count        (count),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_res      (out_res),
    .mem_req      (mem_req),
    .rd_data      (rd_data),
    .nz_flags     (nz_flags)
  );

  bvf_mem u_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (mem_req),
    .rd_data  (rd_data),
    .nz_flags (nz_flags)
  );

  // Result beat packing
  assign out_tdata = {3'b000, out_res.out_of_range, out_res.combined_word,
                      out_res.found_index, out_res.bit_value};

endmodule

`default_nettype wire

[rtl/bvf_mem.sv]
// ----------------------------------------------------------------------------
// bvf_mem - word store of the bit vector
// Synchronous memory with one read and one write port and a registered
// read. Per-word valid bits make unwritten words read as zero after reset;
// per-word nonzero flags feed the word-level search of the find actions.
// ----------------------------------------------------------------------------
`default_nettype none

module bvf_mem
  import bvf_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire mem_req_t             req,
  output logic [WORD_BITS-1:0]      rd_data,
  output logic [NUM_WORDS-1:0]      nz_flags
);

  logic [WORD_BITS-1:0] mem [NUM_WORDS];
  logic [WORD_BITS-1:0] rd_q_r;
  logic                 rd_vld_r;
  logic [NUM_WORDS-1:0] valid_r;
  logic [NUM_WORDS-1:0] nz_r;

  // Memory array: write port and registered read port
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_q_r <= mem[req.rd_addr];
    end
  end

  // Valid and nonzero flags per word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      nz_r     <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (req.wr_en) begin
        valid_r[req.wr_addr] <= 1'b1;
        nz_r[req.wr_addr]    <= |req.wr_data;
      end
      if (req.rd_en) begin
        rd_vld_r <= valid_r[req.rd_addr];
      end
    end
  end

  // A word never written reads as zero
  assign rd_data  = rd_vld_r ? rd_q_r : '0;
  assign nz_flags = nz_r;

endmodule

`default_nettype wire

[rtl/bvf_ctrl.sv]
// ----------------------------------------------------------------------------
// bvf_ctrl - action sequencer of the bit vector finder
// Takes one beat at a time, drives read-modify-write accesses to the word
// store, runs the fill sweep and holds the result in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bvf_ctrl
  import bvf_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // input beat
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire action_t              action,
  input  wire logic [9:0]           bit_index,
  input  wire logic [WIDX_BITS-1:0] word_index,
  input  wire logic [WORD_BITS-1:0] operand_word,
  input  wire logic                 fill_value,
  // active word count, 1..NUM_WORDS
  input  wire logic [CNT_BITS-1:0]  count,
  // result beat
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output result_t                   out_res,
  // word store
  output mem_req_t                  mem_req,
  input  wire logic [WORD_BITS-1:0] rd_data,
  input  wire logic [NUM_WORDS-1:0] nz_flags
);

  state_t                state_r, state_nxt;
  action_t               act_r, act_nxt;
  logic [SHIFT_BITS-1:0] pos_r, pos_nxt;
  logic [WIDX_BITS-1:0]  addr_r, addr_nxt;
  logic                  bad_r, bad_nxt;
  logic                  cand_vld_r, cand_vld_nxt;
  logic [WIDX_BITS-1:0]  cand_r, cand_nxt;
  logic [WORD_BITS-1:0]  opnd_r, opnd_nxt;
  logic                  fill_r, fill_nxt;
  logic [WIDX_BITS-1:0]  fcnt_r, fcnt_nxt;
  result_t               res_r, res_nxt;
  result_t               out_r, out_nxt;
  logic                  out_valid_r, out_valid_nxt;

  logic [WIDX_BITS-1:0]  word_sel;
  logic                  bit_bad, word_bad;
  logic [NUM_WORDS-1:0]  active_mask, above_mask;
  logic [WIDX_BITS:0]    first_any, first_above;
  logic [WORD_BITS-1:0]  bit_mask, masked, new_word;
  logic [FOUND_BITS-1:0] none_index;
  logic                  res_ready, out_free;
  result_t               res;

  // Index decode and word-level search masks
  always_comb begin
    word_sel = bit_index[9:SHIFT_BITS];
    bit_bad  = {1'b0, word_sel} >= count;
    word_bad = {1'b0, word_index} >= count;
    for (int i = 0; i < NUM_WORDS; i++) begin
      active_mask[i] = CNT_BITS'(i) < count;
      above_mask[i]  = WIDX_BITS'(i) > word_sel;
    end
    first_any   = first_flag(nz_flags & active_mask);
    first_above = first_flag(nz_flags & active_mask & above_mask);
  end

  assign none_index = {count, {SHIFT_BITS{1'b0}}};
  assign bit_mask   = WORD_BITS'(1) << pos_r;
  assign masked     = rd_data & (ABOVE_MASK << pos_r);
  assign out_free   = !out_valid_r || out_ready;
  assign in_ready   = (state_r == ST_IDLE);

  // Next state, store accesses and result
  always_comb begin
    state_nxt    = state_r;
    act_nxt      = act_r;
    pos_nxt      = pos_r;
    addr_nxt     = addr_r;
    bad_nxt      = bad_r;
    cand_vld_nxt = cand_vld_r;
    cand_nxt     = cand_r;
    opnd_nxt     = opnd_r;
    fill_nxt     = fill_r;
    fcnt_nxt     = fcnt_r;
    mem_req      = '0;
    res          = '0;
    res_ready    = 1'b0;
    new_word     = rd_data;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          act_nxt      = action;
          pos_nxt      = bit_index[SHIFT_BITS-1:0];
          opnd_nxt     = operand_word;
          fill_nxt     = fill_value;
          fcnt_nxt     = '0;
          addr_nxt     = word_sel;
          bad_nxt      = bit_bad;
          cand_vld_nxt = 1'b0;
          cand_nxt     = '0;
          state_nxt    = ST_EXEC;
          unique case (action)
            ACT_TEST, ACT_SET, ACT_CLEAR: begin
              mem_req.rd_en   = !bit_bad;
              mem_req.rd_addr = word_sel;
            end
            ACT_FIND_FIRST: begin
              bad_nxt         = 1'b0;
              cand_vld_nxt    = first_any[WIDX_BITS];
              cand_nxt        = first_any[WIDX_BITS-1:0];
              mem_req.rd_en   = first_any[WIDX_BITS];
              mem_req.rd_addr = first_any[WIDX_BITS-1:0];
            end
            ACT_FIND_NEXT: begin
              cand_vld_nxt    = first_above[WIDX_BITS];
              cand_nxt        = first_above[WIDX_BITS-1:0];
              mem_req.rd_en   = !bit_bad;
              mem_req.rd_addr = word_sel;
            end
            ACT_AND_WORD, ACT_OR_WORD: begin
              addr_nxt        = word_index;
              bad_nxt         = word_bad;
              mem_req.rd_en   = !word_bad;
              mem_req.rd_addr = word_index;
            end
            ACT_FILL: begin
              bad_nxt   = 1'b0;
              state_nxt = ST_FILL;
            end
            default: ;
          endcase
        end
      end

      ST_EXEC: begin
        res_ready        = 1'b1;
        res.out_of_range = bad_r;
        case (act_r)
          ACT_TEST: begin
            res.bit_value = !bad_r && rd_data[pos_r];
          end
          ACT_SET, ACT_CLEAR: begin
            new_word        = (act_r == ACT_SET) ? (rd_data | bit_mask)
                                                 : (rd_data & ~bit_mask);
            mem_req.wr_en   = !bad_r;
            mem_req.wr_addr = addr_r;
            mem_req.wr_data = new_word;
          end
          ACT_AND_WORD, ACT_OR_WORD: begin
            new_word          = (act_r == ACT_AND_WORD) ? (rd_data & opnd_r)
                                                        : (rd_data | opnd_r);
            mem_req.wr_en     = !bad_r;
            mem_req.wr_addr   = addr_r;
            mem_req.wr_data   = new_word;
            res.combined_word = bad_r ? '0 : new_word;
          end
          ACT_FIND_FIRST: begin
            res.found_index = cand_vld_r ? {1'b0, cand_r, lowest_set(rd_data)} : none_index;
          end
          ACT_FIND_NEXT: begin
            if (bad_r) begin
              res.found_index = none_index;
            end else if (masked != '0) begin
              res.found_index = {1'b0, addr_r, lowest_set(masked)};
            end else if (cand_vld_r) begin
              // nothing above in this word: fetch the next nonzero word
              res_ready       = 1'b0;
              mem_req.rd_en   = 1'b1;
              mem_req.rd_addr = cand_r;
              state_nxt       = ST_SCAN;
            end else begin
              res.found_index = none_index;
            end
          end
          default: ;
        endcase
      end

      ST_SCAN: begin
        res_ready       = 1'b1;
        res.found_index = {1'b0, cand_r, lowest_set(rd_data)};
      end

      // One word a cycle over the words in use
      ST_FILL: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = fcnt_r;
        mem_req.wr_data = fill_r ? ALL_ONES : '0;
        if ({1'b0, fcnt_r} == count - CNT_BITS'(1)) begin
          res_ready = 1'b1;
        end else begin
          fcnt_nxt = fcnt_r + WIDX_BITS'(1);
        end
      end

      ST_HOLD: begin
        res_ready = 1'b1;
        res       = res_r;
      end

      default: state_nxt = ST_IDLE;
    endcase

    // Hand the result to the output register, or park it
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (res_ready) begin
      if (out_free) begin
        out_nxt       = res;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end else begin
        res_nxt   = res;
        state_nxt = ST_HOLD;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    act_r      <= act_nxt;
    pos_r      <= pos_nxt;
    addr_r     <= addr_nxt;
    bad_r      <= bad_nxt;
    cand_vld_r <= cand_vld_nxt;
    cand_r     <= cand_nxt;
    opnd_r     <= opnd_nxt;
    fill_r     <= fill_nxt;
    fcnt_r     <= fcnt_nxt;
    res_r      <= res_nxt;
    out_r      <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_r;

endmodule

`default_nettype wire

[dv/tb_bit_vector_find_next.sv]
// ----------------------------------------------------------------------------
// tb_bit_vector_find_next - self-checking bench for the bit vector finder
// A table of directed beats covers the empty and full vector, the top and
// bottom bit, find next at the last position, word AND/OR extremes, fills
// and out-of-range indices under a clamped words_in_use. Random beats then
// run under several register settings. Every result beat is checked, field
// by field, against the table's expected result or a bench-side model of the store.
// ----------------------------------------------------------------------------
module tb_bit_vector_find_next
  import bvf_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 3000;
  localparam int PHASE_BEATS = 106;

  logic        clk;
  logic        rst_n;
  logic [55:0] in_tdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] out_tdata;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic        cfg_wr_en;
  logic [5:0]  cfg_wr_data;

  // Beat sent but not yet accepted: typed result or model result
  typedef struct {
    bit      exact;
    result_t want;
  } pending_t;

  // One row of the directed table
  typedef struct {
    bit          is_cfg;
    logic [5:0]  cfg_val;
    logic [55:0] beat;
    bit          exact;
    result_t     want;
  } row_t;

  // Bench copy of the store and register
  logic [WORD_BITS-1:0] model_words [NUM_WORDS];
  logic [CNT_BITS-1:0]  model_wiu;

  pending_t sent_q[$];
  result_t  result_q[$];
  row_t     directed_q[$];

  int  in_beats = 0;
  int  mismatches = 0;
  int  quiet_cycles = 0;
  bit  gaps_on;

  bit_vector_find_next dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // 10 ns clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Effective word count after clamping
  function automatic int words_active();
    if (model_wiu == 0) return 1;
    if (model_wiu > NUM_WORDS) return NUM_WORDS;
    return int'(model_wiu);
  endfunction

  function automatic int low_bit(logic [WORD_BITS-1:0] w);
    int pos;
    pos = 0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (w[i]) pos = i;
    end
    return pos;
  endfunction

  // First set bit in words first..cnt-1, else cnt*32
  function automatic logic [FOUND_BITS-1:0] scan_words(int first, int cnt);
    for (int i = first; i < cnt; i++) begin
      if (model_words[i] != '0) return FOUND_BITS'(i * WORD_BITS + low_bit(model_words[i]));
    end
    return FOUND_BITS'(cnt * WORD_BITS);
  endfunction

  // Applies one action to the bench store and returns its result
  function automatic result_t apply_action(logic [55:0] d);
    action_t              act;
    logic [9:0]           bidx;
    logic [4:0]           widx;
    logic [WORD_BITS-1:0] opw;
    logic                 fillv;
    int                   cnt;
    int                   wsel;
    int                   pos;
    logic [WORD_BITS-1:0] above;
    result_t              r;
    act   = action_t'(d[2:0]);
    bidx  = d[12:3];
    widx  = d[17:13];
    opw   = d[49:18];
    fillv = d[50];
    cnt   = words_active();
    wsel  = int'(bidx[9:5]);
    pos   = int'(bidx[4:0]);
    r     = '0;
    case (act)
      ACT_TEST: begin
        if (wsel >= cnt) r.out_of_range = 1'b1;
        else r.bit_value = model_words[wsel][pos];
      end
      ACT_SET: begin
        if (wsel >= cnt) r.out_of_range = 1'b1;
        else model_words[wsel][pos] = 1'b1;
      end
      ACT_CLEAR: begin
        if (wsel >= cnt) r.out_of_range = 1'b1;
        else model_words[wsel][pos] = 1'b0;
      end
      ACT_FIND_FIRST: r.found_index = scan_words(0, cnt);
      ACT_FIND_NEXT: begin
        if (wsel >= cnt) begin
          r.out_of_range = 1'b1;
          r.found_index  = FOUND_BITS'(cnt * WORD_BITS);
        end else begin
          above = model_words[wsel] & (ABOVE_MASK << pos);
          if (above != '0) r.found_index = FOUND_BITS'(wsel * WORD_BITS + low_bit(above));
          else r.found_index = scan_words(wsel + 1, cnt);
        end
      end
      ACT_AND_WORD, ACT_OR_WORD: begin
        if (int'(widx) >= cnt) begin
          r.out_of_range = 1'b1;
        end else begin
          if (act == ACT_AND_WORD) model_words[widx] = model_words[widx] & opw;
          else model_words[widx] = model_words[widx] | opw;
          r.combined_word = model_words[widx];
        end
      end
      default: begin
        for (int i = 0; i < cnt; i++) model_words[i] = fillv ? ALL_ONES : '0;
      end
    endcase
    return r;
  endfunction

  // Field layout of an input beat, highest first
  function automatic logic [55:0] pack_beat(action_t act, logic [9:0] bidx, logic [4:0] widx,
                                            logic [31:0] opw, logic fillv);
    return {5'b0, fillv, opw, widx, bidx, act};
  endfunction

  function automatic void add_beat(bit exact, action_t act, int bidx, int widx,
                                   logic [31:0] opw, logic fillv, logic bv,
                                   int found, logic [31:0] comb, logic oor);
    row_t row;
    row.is_cfg             = 1'b0;
    row.cfg_val            = '0;
    row.beat               = pack_beat(act, 10'(bidx), 5'(widx), opw, fillv);
    row.exact              = exact;
    row.want.bit_value     = bv;
    row.want.found_index   = FOUND_BITS'(found);
    row.want.combined_word = comb;
    row.want.out_of_range  = oor;
    directed_q.push_back(row);
  endfunction

  function automatic void add_cfg(logic [5:0] v);
    row_t row;
    row         = '{default: '0};
    row.is_cfg  = 1'b1;
    row.cfg_val = v;
    directed_q.push_back(row);
  endfunction

  // Random beat, mostly in range, shaped for sparse vectors
  function automatic logic [55:0] random_beat();
    int          pick;
    int          cnt;
    action_t     act;
    logic [9:0]  bidx;
    logic [4:0]  widx;
    logic [31:0] opw;
    logic        fillv;
    cnt  = words_active();
    pick = $urandom_range(0, 99);
    if (pick < 20) act = ACT_SET;
    else if (pick < 32) act = ACT_CLEAR;
    else if (pick < 44) act = ACT_TEST;
    else if (pick < 54) act = ACT_FIND_FIRST;
    else if (pick < 76) act = ACT_FIND_NEXT;
    else if (pick < 86) act = ACT_AND_WORD;
    else if (pick < 96) act = ACT_OR_WORD;
    else act = ACT_FILL;
    if ($urandom_range(0, 9) == 0) bidx = 10'($urandom_range(0, 1023));
    else bidx = 10'($urandom_range(0, cnt * WORD_BITS - 1));
    if ($urandom_range(0, 9) == 0) widx = 5'($urandom_range(0, 31));
    else widx = 5'($urandom_range(0, cnt - 1));
    case ($urandom_range(0, 3))
      0: opw = 32'h1 << $urandom_range(0, 31);
      1: opw = ~(32'h1 << $urandom_range(0, 31));
      default: opw = $urandom;
    endcase
    fillv = ($urandom_range(0, 3) == 0);
    return pack_beat(act, bidx, widx, opw, fillv);
  endfunction

  // Drives one beat from a falling edge and returns once it is taken
  task automatic drive_beat(logic [55:0] d, bit exact, result_t want);
    int       seen;
    pending_t p;
    while (gaps_on && $urandom_range(0, 99) < 8) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    p.exact = exact;
    p.want  = want;
    sent_q.push_back(p);
    seen      = in_beats;
    in_tvalid = 1'b1;
    in_tdata  = d;
    @(negedge clk);
    while (in_beats == seen) @(negedge clk);
  endtask

  // Holds off the sender until every result is back and the block is idle
  task automatic drain();
    in_tvalid = 1'b0;
    while (sent_q.size() != 0 || result_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_words(logic [5:0] v);
    drain();
    cfg_wr_en   = 1'b1;
    cfg_wr_data = v;
    model_wiu   = v;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  // Result side: random stalls
  always @(negedge clk) begin
    out_tready = !(gaps_on && $urandom_range(0, 99) < 8);
  end

  // Accepts beats on both channels and checks results
  always @(posedge clk) begin
    pending_t p;
    result_t  got;
    result_t  want;
    result_t  r;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        p = sent_q.pop_front();
        r = apply_action(in_tdata);
        result_q.push_back(p.exact ? p.want : r);
        in_beats++;
      end
      if (out_tvalid && out_tready) begin
        got = result_t'(out_tdata[44:0]);
        if (result_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat %h", out_tdata);
        end else begin
          want = result_q.pop_front();
          if (got.bit_value !== want.bit_value || got.found_index !== want.found_index ||
              got.combined_word !== want.combined_word ||
              got.out_of_range !== want.out_of_range) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp bit=%b found=%0d word=%h oor=%b, ",
                       want.bit_value, want.found_index, want.combined_word, want.out_of_range,
                       "got bit=%b found=%0d word=%h oor=%b",
                       got.bit_value, got.found_index, got.combined_word, got.out_of_range);
          end
        end
      end
    end
  end

  // Watchdog on cycles with no beat taken on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    row_t    row;
    result_t none;
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = '0;
    gaps_on      = 1'b1;
    none         = '0;
    model_wiu    = 6'd32;
    foreach (model_words[i]) model_words[i] = '0;

    // Directed table; exact rows carry the result, the rest use the model
    add_beat(1, ACT_FIND_FIRST, 0, 0, 0, 0, 0, 1024, 0, 0);
    add_beat(1, ACT_TEST, 0, 0, 0, 0, 0, 0, 0, 0);
    add_beat(1, ACT_SET, 1023, 0, 0, 0, 0, 0, 0, 0);
    add_beat(1, ACT_TEST, 1023, 0, 0, 0, 1, 0, 0, 0);
    add_beat(1, ACT_FIND_FIRST, 0, 0, 0, 0, 0, 1023, 0, 0);
    add_beat(1, ACT_FIND_NEXT, 1023, 0, 0, 0, 0, 1024, 0, 0);
    add_beat(1, ACT_SET, 0, 0, 0, 0, 0, 0, 0, 0);
    add_beat(1, ACT_FIND_NEXT, 0, 0, 0, 0, 0, 1023, 0, 0);
    add_beat(1, ACT_OR_WORD, 0, 31, ALL_ONES, 0, 0, 0, ALL_ONES, 0);
    add_beat(1, ACT_AND_WORD, 0, 31, ABOVE_MASK, 0, 0, 0, ABOVE_MASK, 0);
    add_beat(0, ACT_CLEAR, 1023, 0, 0, 0, 0, 0, 0, 0);
    add_beat(0, ACT_FIND_NEXT, 1, 0, 0, 0, 0, 0, 0, 0);
    add_beat(1, ACT_FILL, 0, 0, 0, 1, 0, 0, 0, 0);
    add_beat(1, ACT_FIND_NEXT, 31, 0, 0, 0, 0, 32, 0, 0);
    add_beat(1, ACT_AND_WORD, 0, 0, 0, 0, 0, 0, 0, 0);
    add_beat(1, ACT_FIND_FIRST, 0, 0, 0, 0, 0, 32, 0, 0);
    add_beat(1, ACT_FILL, 0, 0, 0, 0, 0, 0, 0, 0);
    // Zero register acts as one word
    add_cfg(6'd0);
    add_beat(1, ACT_TEST, 32, 0, 0, 0, 0, 0, 0, 1);
    add_beat(1, ACT_FIND_NEXT, 40, 0, 0, 0, 0, 32, 0, 1);
    add_beat(1, ACT_OR_WORD, 0, 1, ALL_ONES, 0, 0, 0, 0, 1);
    add_beat(1, ACT_SET, 31, 0, 0, 0, 0, 0, 0, 0);
    add_beat(1, ACT_FIND_NEXT, 30, 0, 0, 0, 0, 31, 0, 0);
    add_beat(1, ACT_FILL, 0, 0, 0, 1, 0, 0, 0, 0);
    // Above the maximum acts as all words; fill left words above the first alone
    add_cfg(6'd63);
    add_beat(1, ACT_FIND_NEXT, 31, 0, 0, 0, 0, 1024, 0, 0);
    add_beat(0, ACT_FIND_FIRST, 0, 0, 0, 0, 0, 0, 0, 0);

    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (directed_q[i]) begin
      row = directed_q[i];
      if (row.is_cfg) write_words(row.cfg_val);
      else drive_beat(row.beat, row.exact, row.want);
    end

    // Random phases under several register settings
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: write_words(6'd7);
        1: write_words(6'd1);
        2: write_words(6'd32);
        3: write_words(6'd0);
        4: write_words(6'd17);
        5: write_words(6'd63);
        6: write_words(6'd2);
        default: write_words(6'd24);
      endcase
      gaps_on = (ph != 2);
      for (int n = 0; n < PHASE_BEATS; n++) begin
        if (ph == 4 && n == 50) drain();
        drive_beat(random_beat(), 1'b0, none);
      end
    end
    gaps_on = 1'b1;

    drain();
    repeat (8) @(negedge clk);
    if (mismatches == 0 && result_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/bvf_pkg.sv
rtl/bvf_mem.sv
rtl/bvf_ctrl.sv
rtl/bit_vector_find_next.sv
dv/tb_bit_vector_find_next.sv
